/* rtl/bounded_deque_core_defines.svh */
// Assertion macros shared by the bounded deque RTL.
// Depends on nothing; the top level includes it for its concurrent checks.
`ifndef BOUNDED_DEQUE_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define BDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle, outside reset.
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/bdq_pkg.sv */
// Package for the bounded deque: command and status codes, word width
// and the control struct driven into the cell row. Depends on nothing.
`default_nettype none

package bdq_pkg;

   localparam int WORD_W = 32;

   // Command codes carried by an input word.
   localparam logic [3:0] CMD_PUSH_BACK     = 4'd0;
   localparam logic [3:0] CMD_PUSH_FRONT    = 4'd1;
   localparam logic [3:0] CMD_POP_FRONT     = 4'd2;
   localparam logic [3:0] CMD_POP_BACK      = 4'd3;
   localparam logic [3:0] CMD_PEEK_FRONT    = 4'd4;
   localparam logic [3:0] CMD_PEEK_BACK     = 4'd5;
   localparam logic [3:0] CMD_SIZE          = 4'd6;
   localparam logic [3:0] CMD_CLEAR         = 4'd7;
   localparam logic [3:0] CMD_DUMP          = 4'd8;
   localparam logic [3:0] CMD_DUMP_REVERSED = 4'd9;

   // Status codes carried by a result word.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Per-cycle movement of the cell row.
   typedef struct packed {
      logic shift_from_front;  // every cell takes its front neighbour's word
      logic shift_to_front;    // every cell takes its back neighbour's word
      logic write_back;        // the addressed cell takes the pushed word
   } row_ctrl_type;

endpackage

`default_nettype wire

/* rtl/bdq_channels.sv */
// Handshake interfaces for the command and result channels of the deque.
// Depends on bdq_pkg for the word width.
`default_nettype none

interface bdq_req_if;
   import bdq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [3:0]               cmd;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bdq_rsp_if;
   import bdq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] data;
   logic [1:0]               status;
   logic                     last;

   modport source (output valid, output data, output status, output last, input ready);
   modport sink   (input valid, input data, input status, input last, output ready);
endinterface

`default_nettype wire

/* rtl/bdq_cell.sv */
// One storage cell of the deque row: holds a word and trades it with its
// neighbours. Depends on bdq_pkg for the control struct and word width.
`default_nettype none

module bdq_cell
   import bdq_pkg::*;
#(
   parameter int IW    = 6,
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire row_ctrl_type      ctrl,
   input  wire logic [IW-1:0]     wr_idx,
   input  wire logic [WORD_W-1:0] wr_value,
   input  wire logic [IW-1:0]     rd_idx,
   input  wire logic [WORD_W-1:0] front_data,
   input  wire logic [WORD_W-1:0] back_data,
   output logic      [WORD_W-1:0] data_out,
   output logic      [WORD_W-1:0] rd_term
);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   // Next word: shift towards the back, shift towards the front, or write.
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_from_front) begin
         data_in = front_data;
      end else if (ctrl.shift_to_front) begin
         data_in = back_data;
      end else if (ctrl.write_back && (wr_idx == IW'(INDEX))) begin
         data_in = wr_value;
      end
   end

   // Stored word; contents are undefined until written, so no reset.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

   // Contribution to the shared read bus when this cell is addressed.
   assign rd_term = (rd_idx == IW'(INDEX)) ? data_ff : '0;

endmodule

`default_nettype wire

/* rtl/bdq_cell_row.sv */
// Row of deque cells, front at cell zero, with the shared read bus.
// Depends on bdq_pkg and bdq_cell.
`default_nettype none

module bdq_cell_row
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                        clock,
   input  wire row_ctrl_type                ctrl,
   input  wire logic [$clog2(DEPTH)-1:0]    wr_idx,
   input  wire logic [WORD_W-1:0]           wr_value,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_idx,
   output logic      [WORD_W-1:0]           rd_data
);

   localparam int IW = $clog2(DEPTH);

   logic [WORD_W-1:0] cell_data [DEPTH];
   logic [WORD_W-1:0] cell_term [DEPTH];

   // Cell zero takes the pushed word on a front push; the last cell
   // keeps its own word when the row shifts towards the front.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [WORD_W-1:0] front_word;
      logic [WORD_W-1:0] back_word;

      if (k == 0) begin : g_head
         assign front_word = wr_value;
      end else begin : g_inner_f
         assign front_word = cell_data[k-1];
      end

      if (k == DEPTH - 1) begin : g_tail
         assign back_word = cell_data[k];
      end else begin : g_inner_b
         assign back_word = cell_data[k+1];
      end

      bdq_cell #(
         .IW    (IW),
         .INDEX (k)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .wr_idx     (wr_idx),
         .wr_value   (wr_value),
         .rd_idx     (rd_idx),
         .front_data (front_word),
         .back_data  (back_word),
         .data_out   (cell_data[k]),
         .rd_term    (cell_term[k])
      );
   end

   // Only the addressed cell drives a non-zero term, so an OR collects it.
   always_comb begin
      rd_data = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_data = rd_data | cell_term[k];
      end
   end

endmodule

`default_nettype wire

/* rtl/bounded_deque_core.sv */
// Bounded deque core: a result word is registered in the cycle after its command
// is taken; a dump's words are registered from the dump state that it enters.
// Single-result commands are taken every cycle while the result register drains;
// a dump holds the command channel until its last word is registered. Synchronous
// active-high reset empties the queue and the result register, not the cells.
// Depends on bdq_pkg, bdq_channels, bdq_cell_row and the defines header.
`default_nettype none

`include "bounded_deque_core_defines.svh"

module bounded_deque_core
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bdq_req_if.sink    req_chan,
   bdq_rsp_if.source  rsp_chan
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } dq_state_type;

   dq_state_type      state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     dump_idx_ff, dump_idx_in;
   logic              dump_rev_ff, dump_rev_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_last_ff;

   row_ctrl_type      ctrl;
   logic [IW-1:0]     rd_idx;
   logic [WORD_W-1:0] rd_data;
   logic              take_out;
   logic              req_accept;
   logic              is_full;
   logic              is_empty;
   logic [IW-1:0]     back_idx;
   logic              dump_done;
   logic              out_load;
   logic [WORD_W-1:0] out_data;
   logic [1:0]        out_status;
   logic              out_last;
   logic              in_dump;
   logic              push_refused;

   // Handshake: the result register frees when empty or being taken.
   assign take_out   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && take_out;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign back_idx  = IW'(count_ff - CW'(1));
   assign dump_done = ((CW'(dump_idx_ff) + CW'(1)) == count_ff);

   bdq_cell_row #(
      .DEPTH (DEPTH)
   ) u_row (
      .clock    (clock),
      .ctrl     (ctrl),
      .wr_idx   (IW'(count_ff)),
      .wr_value (req_chan.value),
      .rd_idx   (rd_idx),
      .rd_data  (rd_data)
   );

   // Command decode, row control and the dump sequencer.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      dump_rev_in = dump_rev_ff;
      ctrl        = '0;
      rd_idx      = '0;
      out_load    = 1'b0;
      out_data    = '0;
      out_status  = STATUS_OK;
      out_last    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_chan.cmd)
                  CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                     out_load = 1'b1;
                     if (is_full) begin
                        out_status = STATUS_FULL;
                     end else begin
                        ctrl.write_back       = (req_chan.cmd == CMD_PUSH_BACK);
                        ctrl.shift_from_front = (req_chan.cmd == CMD_PUSH_FRONT);
                        count_in = count_ff + CW'(1);
                        out_data = req_chan.value;
                     end
                  end
                  CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                     out_load = 1'b1;
                     if (is_empty) begin
                        out_status = STATUS_EMPTY;
                     end else begin
                        out_data = rd_data;
                        if (req_chan.cmd == CMD_POP_FRONT) begin
                           ctrl.shift_to_front = 1'b1;
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end
                  CMD_POP_BACK, CMD_PEEK_BACK: begin
                     out_load = 1'b1;
                     rd_idx   = back_idx;
                     if (is_empty) begin
                        out_status = STATUS_EMPTY;
                     end else begin
                        out_data = rd_data;
                        if (req_chan.cmd == CMD_POP_BACK) begin
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end
                  CMD_SIZE: begin
                     out_load = 1'b1;
                     out_data = WORD_W'(count_ff);
                  end
                  CMD_CLEAR: begin
                     out_load   = 1'b1;
                     out_status = STATUS_EMPTY;
                     count_in   = '0;
                  end
                  CMD_DUMP, CMD_DUMP_REVERSED: begin
                     if (is_empty) begin
                        out_load   = 1'b1;
                        out_status = STATUS_EMPTY;
                     end else begin
                        state_in    = ST_DUMP;
                        dump_idx_in = '0;
                        dump_rev_in = (req_chan.cmd == CMD_DUMP_REVERSED);
                     end
                  end
                  default: begin
                     // Unknown codes are consumed without a result.
                  end
               endcase
            end
         end
         ST_DUMP: begin
            rd_idx = dump_rev_ff ? IW'(count_ff - CW'(1) - CW'(dump_idx_ff))
                                 : dump_idx_ff;
            if (take_out) begin
               out_load    = 1'b1;
               out_data    = rd_data;
               out_last    = dump_done;
               dump_idx_in = dump_idx_ff + IW'(1);
               if (dump_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = take_out ? out_load : rsp_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         dump_rev_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         dump_rev_ff  <= dump_rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (take_out && out_load) begin
         rsp_data_ff   <= out_data;
         rsp_status_ff <= out_status;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.last   = rsp_last_ff;

   // Terms used by the checks below.
   assign in_dump      = (state_ff == ST_DUMP);
   assign push_refused = req_accept && is_full &&
                         (req_chan.cmd == CMD_PUSH_BACK || req_chan.cmd == CMD_PUSH_FRONT);

   // Concurrent checks on the sequencer and the entry count.
   `BDQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count above depth")
   `BDQ_ASSERT_SAME(a_dump_blocks, clock, reset, in_dump, !req_chan.ready, "command taken in dump")
   `BDQ_ASSERT_NEXT(a_dump_count, clock, reset, in_dump, $stable(count_ff), "count moved in dump")
   `BDQ_ASSERT_NEXT(a_full_push, clock, reset, push_refused, is_full, "refused push changed count")

endmodule

`default_nettype wire
